// File: sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants for the circular deque unit
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int CAP_W    = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd15;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_NOP        = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;   // apply the accepted beat to the indices and the store
    logic read;   // fetch front and rear words
    logic load;   // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_room;  // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

// File: sv/cdq_ifs.sv
// ----------------------------------------------------------------------------
// cdq channel interfaces
// valid/ready channels for operation, result and capacity beats
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_in_if;
  import cdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] rear_value;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

interface cdq_cfg_if;
  import cdq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] max_items;

  modport source (output valid, output max_items, input ready);
  modport sink   (input valid, input max_items, output ready);
endinterface

`default_nettype wire

// File: sv/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// File: sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// sequencer: accept a beat, fetch the ends, hand the result over
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cdq_pkg::status_t status,
  output cdq_pkg::cmd_t         cmd
);
  import cdq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_room) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/cdq_dpath.sv
// ----------------------------------------------------------------------------
// cdq_dpath
// ring indices, capacity register, slot store and output register
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_dpath #(
  parameter int RING_SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cdq_pkg::cmd_t                 cmd,
  output cdq_pkg::status_t                   status,
  input  wire logic [cdq_pkg::OP_W-1:0]      in_opcode,
  input  wire logic signed [cdq_pkg::WORD_W-1:0] in_push_value,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cdq_pkg::CAP_W-1:0]     cfg_max_items,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_ok,
  output logic signed [cdq_pkg::WORD_W-1:0]  out_front_value,
  output logic signed [cdq_pkg::WORD_W-1:0]  out_rear_value,
  output logic                               out_is_empty,
  output logic                               out_is_full
);
  import cdq_pkg::*;

  localparam int IDX_W = $clog2(RING_SLOTS);
  localparam int SZ_W  = IDX_W + 1;
  localparam int CMP_W = (SZ_W > CAP_W + 1) ? SZ_W : CAP_W + 1;

  logic [CAP_W-1:0] max_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic             ok_r, ok_nxt;

  logic [CMP_W-1:0] n_items;
  logic [CMP_W-1:0] size_want;
  logic [CMP_W-1:0] ring_size;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] front_next, front_prev, back_next, back_prev;
  logic             is_empty, is_full;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [WORD_W-1:0] rd_front, rd_rear;

  logic                     out_valid_r;
  logic                     out_ok_r;
  logic signed [WORD_W-1:0] out_front_r, out_rear_r;
  logic                     out_empty_r, out_full_r;

  // ring size = max(max_items, 1) + 1, capped at the physical slot count
  always_comb begin
    n_items   = (max_r == '0) ? CMP_W'(1) : CMP_W'(max_r);
    size_want = n_items + CMP_W'(1);
    ring_size = (size_want > CMP_W'(RING_SLOTS)) ? CMP_W'(RING_SLOTS) : size_want;
    last_idx  = IDX_W'(ring_size - CMP_W'(1));
  end

  // indices always stay below the ring size, so wrap tests are simple
  always_comb begin
    front_next = (front_r == last_idx) ? '0 : front_r + IDX_W'(1);
    front_prev = (front_r == '0) ? last_idx : front_r - IDX_W'(1);
    back_next  = (back_r == last_idx) ? '0 : back_r + IDX_W'(1);
    back_prev  = (back_r == '0) ? last_idx : back_r - IDX_W'(1);
    is_empty   = (front_r == back_r);
    is_full    = (back_next == front_r);
  end

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    ok_nxt    = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = back_r;
    unique case (opcode_t'(in_opcode))
      OP_PUSH_FRONT: begin
        if (is_full) begin
          ok_nxt = 1'b0;
        end else begin
          front_nxt = front_prev;
          ram_we    = cmd.exec;
          ram_waddr = front_prev;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          ok_nxt = 1'b0;
        end else begin
          back_nxt  = back_next;
          ram_we    = cmd.exec;
          ram_waddr = back_r;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          ok_nxt = 1'b0;
        end else begin
          front_nxt = front_next;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          ok_nxt = 1'b0;
        end else begin
          back_nxt = back_prev;
        end
      end
      default: begin
        ok_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= CAP_RESET;
      front_r <= '0;
      back_r  <= '0;
    end else if (cfg_valid) begin
      max_r   <= cfg_max_items;
      front_r <= '0;
      back_r  <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r <= ok_nxt;
    end
  end

  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_push_value),
    .re      (cmd.read),
    .raddr_a (front_r),
    .raddr_b (back_prev),
    .rdata_a (rd_front),
    .rdata_b (rd_rear)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ok_r    <= ok_r;
      out_front_r <= is_empty ? '0 : rd_front;
      out_rear_r  <= is_empty ? '0 : rd_rear;
      out_empty_r <= is_empty;
      out_full_r  <= is_full;
    end
  end

  assign status.out_room = !out_valid_r || out_ready;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

endmodule

`default_nettype wire

// File: sv/circular_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_deque_unit
// bounded double-ended queue of signed words held in a ring of slots
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                                        purpose
//   in_ch     in    opcode, push_value                             one operation
//   out_ch    out   ok, front_value, rear_value, is_empty, is_full state after it
//   cfg_ch    in    max_items                                      capacity, clears
//
// each operation runs in order: apply and write the store, read both
// ends from the store's registered port, load the output register
// the next operation is taken while a result still waits in the output
// register; only the load step waits on out_ch.ready
// reset empties the deque and sets the capacity to fifteen
// a capacity beat clears both indices and is taken at any time
//
`default_nettype none

module circular_deque_unit #(
  parameter int RING_SLOTS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cdq_in_if.sink     in_ch,
  cdq_out_if.source  out_ch,
  cdq_cfg_if.sink    cfg_ch
);
  import cdq_pkg::*;

  cmd_t    cmd;     // sequencer commands
  status_t status;  // datapath feedback

  // sequencer: idle, read, load
  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // indices, store and output register
  cdq_dpath #(
    .RING_SLOTS (RING_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_opcode       (in_ch.opcode),
    .in_push_value   (in_ch.push_value),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_max_items   (cfg_ch.max_items),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_ok          (out_ch.ok),
    .out_front_value (out_ch.front_value),
    .out_rear_value  (out_ch.rear_value),
    .out_is_empty    (out_ch.is_empty),
    .out_is_full     (out_ch.is_full)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for circular_deque_unit: a directed opening and then
// random operation streams under several capacities, predicted beat by beat
// by a model of the ring and compared field by field on the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int RING_SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int PIPE_CYCLES = 4;

  // opcodes outside the enum behave as no operation
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hffff_ffff;

  typedef struct {
    logic [OP_W-1:0]   opcode;
    logic [WORD_W-1:0] push_value;
  } op_beat_t;

  // state of the deque as one result beat shows it
  typedef struct {
    logic              ok;
    logic [WORD_W-1:0] front_value;
    logic [WORD_W-1:0] rear_value;
    logic              is_empty;
    logic              is_full;
  } deque_view_t;

  logic clk;
  logic rst_n;

  cdq_in_if  in_ch();
  cdq_out_if out_ch();
  cdq_cfg_if cfg_ch();

  circular_deque_unit #(.RING_SLOTS(RING_SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // ring model of the deque
  logic [WORD_W-1:0] ring_words [RING_SLOTS];
  logic [CAP_W-1:0]  cap_reg;
  logic [3:0]        head_idx;
  logic [3:0]        tail_idx;

  op_beat_t    op_backlog [$];
  deque_view_t awaited [$];

  int mismatches;
  int results_seen;
  int refused_ops;
  int full_views;
  int cap_writes;
  int ops_by_code [8];
  bit drain_hold;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  // zero capacity acts as one; the ring never exceeds the physical slots
  function automatic int unsigned ring_len(logic [CAP_W-1:0] cap);
    int unsigned n;
    n = (cap == '0) ? 1 : int'(cap);
    n = n + 1;
    if (n > RING_SLOTS) n = RING_SLOTS;
    return n;
  endfunction

  function automatic int unsigned wrap_up(int unsigned i, int unsigned n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  function automatic int unsigned wrap_down(int unsigned i, int unsigned n);
    return (i == 0 || i >= n) ? n - 1 : i - 1;
  endfunction

  // applies one operation to the ring and returns the view after it
  function automatic deque_view_t apply_op(logic [OP_W-1:0] op, logic [WORD_W-1:0] val);
    deque_view_t v;
    int unsigned n;
    bit was_empty;
    bit was_full;
    n = ring_len(cap_reg);
    was_empty = (head_idx == tail_idx);
    was_full  = (wrap_up(tail_idx, n) == head_idx);
    v.ok = 1'b1;
    case (op)
      OP_PUSH_FRONT: begin
        if (was_full) v.ok = 1'b0;
        else begin
          // front moves back first, then the word lands there
          head_idx = 4'(wrap_down(head_idx, n));
          ring_words[head_idx] = val;
        end
      end
      OP_PUSH_BACK: begin
        if (was_full) v.ok = 1'b0;
        else begin
          ring_words[tail_idx] = val;
          tail_idx = 4'(wrap_up(tail_idx, n));
        end
      end
      OP_POP_FRONT: begin
        if (was_empty) v.ok = 1'b0;
        else head_idx = 4'(wrap_up(head_idx, n));
      end
      OP_POP_BACK: begin
        if (was_empty) v.ok = 1'b0;
        else tail_idx = 4'(wrap_down(tail_idx, n));
      end
      default: ;
    endcase
    v.is_empty = (head_idx == tail_idx);
    v.is_full  = (wrap_up(tail_idx, n) == head_idx);
    // an empty deque shows zero at both ends
    v.front_value = v.is_empty ? '0 : ring_words[head_idx];
    v.rear_value  = v.is_empty ? '0 : ring_words[wrap_down(tail_idx, n)];
    return v;
  endfunction

  task automatic flag_mismatch(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    mismatches++;
    $display("result %0d: %s got %h want %h", results_seen, field, got, want);
  endtask

  // --------------------------------------------------------------- driver

  // sends pending operations in bursts with gaps, now and then holding off
  // until every awaited result has drained
  always @(posedge clk) begin : drive_ops
    op_beat_t beat;
    int unsigned burst_left;
    int unsigned gap_left;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      // accepted beat: predict its result now
      if (in_ch.valid && in_ch.ready) begin
        awaited.push_back(apply_op(in_ch.opcode, in_ch.push_value));
        ops_by_code[in_ch.opcode]++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (drain_hold) begin
          in_ch.valid <= 1'b0;
          if (awaited.size() == 0) drain_hold = 1'b0;
        end else if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else if (op_backlog.size() > 0) begin
          beat = op_backlog.pop_front();
          in_ch.opcode     <= beat.opcode;
          in_ch.push_value <= beat.push_value;
          in_ch.valid      <= 1'b1;
          if (burst_left == 0) begin
            // long unbroken stretches now and then
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 11) == 0) drain_hold = 1'b1;
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------- receiver

  // ready follows a rotating stall pattern, reloaded every so often
  always @(posedge clk) begin : drive_ready
    logic [15:0] stall_pat;
    int unsigned pat_left;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      pat_left = 0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 16'hffff;
          1: stall_pat = 16'h0001 << $urandom_range(0, 15);
          default: stall_pat = 16'($urandom) | 16'h0001;
        endcase
        pat_left = $urandom_range(16, 96);
      end else begin
        pat_left--;
      end
      out_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // -------------------------------------------------------------- monitor

  always @(posedge clk) begin : check_results
    deque_view_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        flag_mismatch("unexpected beat, front", out_ch.front_value, '0);
      end else begin
        want = awaited.pop_front();
        if (!want.ok) refused_ops++;
        if (want.is_full) full_views++;
        if (out_ch.ok !== want.ok)
          flag_mismatch("ok", WORD_W'(out_ch.ok), WORD_W'(want.ok));
        if (out_ch.front_value !== want.front_value)
          flag_mismatch("front_value", out_ch.front_value, want.front_value);
        if (out_ch.rear_value !== want.rear_value)
          flag_mismatch("rear_value", out_ch.rear_value, want.rear_value);
        if (out_ch.is_empty !== want.is_empty)
          flag_mismatch("is_empty", WORD_W'(out_ch.is_empty), WORD_W'(want.is_empty));
        if (out_ch.is_full !== want.is_full)
          flag_mismatch("is_full", WORD_W'(out_ch.is_full), WORD_W'(want.is_full));
      end
    end
  end

  // ------------------------------------------------------------- watchdog

  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------- stimulus

  task automatic queue_op(logic [OP_W-1:0] op, logic [WORD_W-1:0] val);
    op_beat_t b;
    b.opcode = op;
    b.push_value = val;
    op_backlog.push_back(b);
  endtask

  // waits until every queued beat went in and every result came out,
  // then lets the three-stage pipe run empty
  task automatic wait_quiet();
    do @(posedge clk);
    while (op_backlog.size() != 0 || in_ch.valid || drain_hold || awaited.size() != 0);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // capacity beat, only ever sent with the deque idle; it also clears it
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_quiet();
    cfg_ch.max_items <= cap;
    cfg_ch.valid     <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_reg  = cap;
    head_idx = '0;
    tail_idx = '0;
    cap_writes++;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return WORD_ONES;
      4: return WORD_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // random operations; each stretch leans to filling, draining or neither
  task automatic random_ops(int count);
    int lean;
    int r;
    logic [OP_W-1:0] op;
    lean = 0;
    for (int i = 0; i < count; i++) begin
      // first stretch of a phase always leans to filling
      if (i % 30 == 0) lean = (i == 0) ? 0 : $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else if (r < 8) op = OP_NOP;
      else begin
        case (lean)
          0: op = ($urandom_range(0, 99) < 80) ? OP_W'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK))
                                               : OP_W'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
          1: op = ($urandom_range(0, 99) < 75) ? OP_W'($urandom_range(OP_POP_FRONT, OP_POP_BACK))
                                               : OP_W'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK));
          default: op = OP_W'($urandom_range(OP_PUSH_FRONT, OP_POP_BACK));
        endcase
      end
      queue_op(op, pick_word());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_NOP;
    in_ch.push_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_items = CAP_RESET;
    drain_hold = 1'b0;
    cap_reg = CAP_RESET;
    head_idx = '0;
    tail_idx = '0;
    foreach (ring_words[i]) ring_words[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // capacity zero behaves as one: second push refused, pops on empty refused
    write_capacity('0);
    queue_op(OP_PUSH_BACK, WORD_MIN);
    queue_op(OP_PUSH_FRONT, WORD_MAX);
    queue_op(OP_POP_BACK, '0);
    queue_op(OP_POP_FRONT, '0);
    queue_op(OP_PUSH_FRONT, WORD_ONES);
    queue_op(OP_NOP, WORD_MAX);
    queue_op(OP_SPARE_FIRST, WORD_MIN);
    queue_op(OP_SPARE_FIRST + 3'd1, WORD_ONES);
    queue_op(OP_SPARE_LAST, '0);
    queue_op(OP_POP_FRONT, '0);

    // capacity two: both ends, refusal when full, refusal when empty
    write_capacity(4'd2);
    queue_op(OP_PUSH_FRONT, WORD_MIN);
    queue_op(OP_PUSH_BACK, WORD_MAX);
    queue_op(OP_PUSH_FRONT, '0);
    queue_op(OP_POP_FRONT, '0);
    queue_op(OP_POP_BACK, '0);
    queue_op(OP_POP_BACK, '0);
    queue_op(OP_PUSH_BACK, WORD_ONES);
    queue_op(OP_NOP, '0);

    // random phases over a spread of capacities, extremes included
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, PHASES - 1: cap = 4'd15;
        1: cap = 4'd1;
        2: cap = 4'd0;
        default: cap = CAP_W'($urandom_range(2, 14));
      endcase
      write_capacity(cap);
      random_ops(ITEMS_PER_PHASE);
    end

    wait_quiet();
    repeat (2 * PIPE_CYCLES) @(posedge clk);

    $display("covered %0d beats: push front %0d, push back %0d, pop front %0d, pop back %0d",
             results_seen, ops_by_code[OP_PUSH_FRONT], ops_by_code[OP_PUSH_BACK],
             ops_by_code[OP_POP_FRONT], ops_by_code[OP_POP_BACK]);
    $display("idle or spare codes %0d, refused %0d, full views %0d, capacity writes %0d",
             ops_by_code[OP_NOP] + ops_by_code[5] + ops_by_code[6] + ops_by_code[7],
             refused_ops, full_views, cap_writes);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
